// ===== rtl/lsmt_pkg.sv =====
package lsmt_pkg;

  localparam int DOT_W  = 10;
  localparam int LINE_W = 8;
  localparam int MODE_W = 2;
  localparam int ELAP_W = 8;
  localparam int IDX_W  = 3;
  localparam int CFG_W  = 8;
  localparam int RES_W  = 16;

  localparam logic [DOT_W-1:0]  LINE_CYCLES     = DOT_W'(456);
  localparam logic [DOT_W-1:0]  OAM_CYCLES      = DOT_W'(80);
  localparam logic [DOT_W-1:0]  TRANSFER_CYCLES = DOT_W'(172);
  localparam logic [LINE_W-1:0] VISIBLE_LINES   = LINE_W'(144);
  localparam logic [LINE_W-1:0] LAST_LINE       = LINE_W'(153);

  // Lowest dot counter values of OAM search and of transfer.
  localparam logic [DOT_W-1:0] OAM_START      = LINE_CYCLES - OAM_CYCLES;
  localparam logic [DOT_W-1:0] TRANSFER_START = LINE_CYCLES - OAM_CYCLES - TRANSFER_CYCLES;

  localparam logic [MODE_W-1:0] MODE_HBLANK   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_VBLANK   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_OAM      = 2'd2;
  localparam logic [MODE_W-1:0] MODE_TRANSFER = 2'd3;

  localparam logic [IDX_W-1:0] REG_DISPLAY_ENABLE = 3'd0;
  localparam logic [IDX_W-1:0] REG_HBLANK_IRQ_EN  = 3'd1;
  localparam logic [IDX_W-1:0] REG_VBLANK_IRQ_EN  = 3'd2;
  localparam logic [IDX_W-1:0] REG_OAM_IRQ_EN     = 3'd3;
  localparam logic [IDX_W-1:0] REG_COMPARE_IRQ_EN = 3'd4;
  localparam logic [IDX_W-1:0] REG_LINE_COMPARE   = 3'd5;

  typedef struct packed {
    logic              display_enable;
    logic              hblank_irq_enable;
    logic              vblank_mode_irq_enable;
    logic              oam_irq_enable;
    logic              compare_irq_enable;
    logic [LINE_W-1:0] line_compare;
  } cfg_t;

  typedef struct packed {
    logic [LINE_W-1:0] line_number;
    logic [MODE_W-1:0] lcd_mode;
    logic              coincidence;
    logic              stat_irq;
    logic              vblank_irq;
  } result_t;

endpackage

// ===== rtl/lsmt_cfg.sv =====
module lsmt_cfg (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wen,
  input  logic [lsmt_pkg::IDX_W-1:0] cfg_addr,
  input  logic [lsmt_pkg::CFG_W-1:0] cfg_wdata,
  output lsmt_pkg::cfg_t        cfg
);
  import lsmt_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.display_enable         <= 1'b1;
      cfg.hblank_irq_enable      <= 1'b0;
      cfg.vblank_mode_irq_enable <= 1'b0;
      cfg.oam_irq_enable         <= 1'b0;
      cfg.compare_irq_enable     <= 1'b0;
      cfg.line_compare           <= '0;
    end else if (cfg_wen) begin
      case (cfg_addr)
        REG_DISPLAY_ENABLE: cfg.display_enable         <= cfg_wdata[0];
        REG_HBLANK_IRQ_EN:  cfg.hblank_irq_enable      <= cfg_wdata[0];
        REG_VBLANK_IRQ_EN:  cfg.vblank_mode_irq_enable <= cfg_wdata[0];
        REG_OAM_IRQ_EN:     cfg.oam_irq_enable         <= cfg_wdata[0];
        REG_COMPARE_IRQ_EN: cfg.compare_irq_enable     <= cfg_wdata[0];
        REG_LINE_COMPARE:   cfg.line_compare           <= cfg_wdata[LINE_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/lsmt_core.sv =====
module lsmt_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  logic [lsmt_pkg::ELAP_W-1:0] elapsed,
  input  lsmt_pkg::cfg_t              cfg,
  output lsmt_pkg::result_t           res
);
  import lsmt_pkg::*;

  logic [DOT_W-1:0]  dot_counter, dot_counter_next;
  logic [LINE_W-1:0] scan_line, scan_line_next;
  logic [MODE_W-1:0] current_mode, mode_next;
  logic              coincidence_flag, coin_next;
  logic              stat, vblank, mode_irq_en, underflow;
  logic [LINE_W-1:0] line_inc;
  logic [DOT_W-1:0]  elapsed_ext;

  assign elapsed_ext = DOT_W'(elapsed);
  assign underflow   = elapsed_ext >= dot_counter;
  assign line_inc    = scan_line + LINE_W'(1);

  always_comb begin
    if (scan_line >= VISIBLE_LINES) begin
      mode_next = MODE_VBLANK;
    end else if (dot_counter >= OAM_START) begin
      mode_next = MODE_OAM;
    end else if (dot_counter >= TRANSFER_START) begin
      mode_next = MODE_TRANSFER;
    end else begin
      mode_next = MODE_HBLANK;
    end

    case (mode_next)
      MODE_HBLANK: mode_irq_en = cfg.hblank_irq_enable;
      MODE_VBLANK: mode_irq_en = cfg.vblank_mode_irq_enable;
      MODE_OAM:    mode_irq_en = cfg.oam_irq_enable;
      default:     mode_irq_en = 1'b0;
    endcase

    stat             = 1'b0;
    vblank           = 1'b0;
    coin_next        = coincidence_flag;
    dot_counter_next = dot_counter;
    scan_line_next   = scan_line;

    if (!cfg.display_enable) begin
      dot_counter_next = LINE_CYCLES;
      scan_line_next   = '0;
      mode_next        = MODE_VBLANK;
    end else begin
      coin_next = scan_line == cfg.line_compare;
      stat      = (mode_next != current_mode && mode_irq_en) ||
                  (coin_next && cfg.compare_irq_enable);
      if (underflow) begin
        // Leftover cycles past the end of the line are dropped.
        dot_counter_next = LINE_CYCLES;
        vblank           = line_inc == VISIBLE_LINES;
        scan_line_next   = (line_inc > LAST_LINE) ? '0 : line_inc;
      end else begin
        dot_counter_next = dot_counter - elapsed_ext;
      end
    end

    res.line_number = scan_line_next;
    res.lcd_mode    = mode_next;
    res.coincidence = coin_next;
    res.stat_irq    = stat;
    res.vblank_irq  = vblank;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dot_counter      <= LINE_CYCLES;
      scan_line        <= '0;
      current_mode     <= MODE_HBLANK;
      coincidence_flag <= 1'b0;
    end else if (step) begin
      dot_counter      <= dot_counter_next;
      scan_line        <= scan_line_next;
      current_mode     <= mode_next;
      coincidence_flag <= coin_next;
    end
  end

  a_dot_range: assert property (@(posedge clk) disable iff (rst)
    dot_counter != '0 && dot_counter <= LINE_CYCLES)
    else $error("dot counter left its range");

  a_line_range: assert property (@(posedge clk) disable iff (rst)
    scan_line <= LAST_LINE)
    else $error("scan line beyond last line");

  a_vblank_line: assert property (@(posedge clk) disable iff (rst)
    res.vblank_irq |-> res.line_number == VISIBLE_LINES && dot_counter_next == LINE_CYCLES)
    else $error("vblank request away from the first invisible line");

  a_off_quiet: assert property (@(posedge clk) disable iff (rst)
    !cfg.display_enable |-> !res.stat_irq && !res.vblank_irq && res.lcd_mode == MODE_VBLANK)
    else $error("request raised while the display is off");

endmodule

// ===== rtl/lcd_scanline_mode_timer.sv =====
// LCD scanline mode timer.
// Input stream: each word on s_tdata is the CPU time elapsed since
// the previous word. Every accepted word yields exactly one result word on
// m_tdata with the current line, the LCD mode, the coincidence flag and the
// STAT and vblank interrupt requests of that step.
// Configuration is written through cfg_wen/cfg_addr/cfg_wdata; the user
// writes it only while the block is idle, which the block does not
// enforce: 0 display enable, 1..4 STAT interrupt enables (hblank,
// vblank, OAM, compare), 5 line compare value.
// Each word passes the input register, then the result register.
// Throughput: one word per cycle while m_tready is high; the timing state
// updates in the same cycle the word moves from the input register into
// the result register.
// Reset (rst, synchronous) turns the display on, clears the interrupt enables
// and compare value, and starts at line 0 with a full line of dots.
// When m_tready is low, a full result register holds; the input register still
// takes one more word, and s_tready drops only when both are full.
module lcd_scanline_mode_timer (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [7:0]                   s_tdata,   // [7:0] elapsed_cycles
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // [7:0] line_number, [9:8] lcd_mode, [10] coincidence, [11] stat_irq,
  // [12] vblank_irq, [15:13] zero
  output logic [lsmt_pkg::RES_W-1:0]   m_tdata,
  input  logic                         cfg_wen,
  input  logic [lsmt_pkg::IDX_W-1:0]   cfg_addr,
  input  logic [lsmt_pkg::CFG_W-1:0]   cfg_wdata
);
  import lsmt_pkg::*;

  cfg_t              cfg;
  result_t           res;
  logic              in_valid;
  logic [ELAP_W-1:0] in_elapsed;
  logic              fire;

  assign fire     = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || fire;

  lsmt_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  lsmt_core u_core (
    .clk     (clk),
    .rst     (rst),
    .step    (fire),
    .elapsed (in_elapsed),
    .cfg     (cfg),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        in_valid <= 1'b1;
      end else if (fire) begin
        in_valid <= 1'b0;
      end
      if (fire) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_elapsed <= s_tdata;
    end
    if (fire) begin
      m_tdata <= {3'b000, res.vblank_irq, res.stat_irq, res.coincidence,
                  res.lcd_mode, res.line_number};
    end
  end

  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    in_valid && !fire |=> in_valid && $stable(in_elapsed))
    else $error("input word lost before it was processed");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import lsmt_pkg::*;

  localparam int LATENCY     = 2;
  localparam int CYCLE_LIMIT = 400000;

  // Indexes above the last register; the block must ignore writes to them.
  localparam logic [IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [IDX_W-1:0] REG_SPARE_HI = 3'd7;

  logic               clk = 1'b0;
  logic               rst;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [7:0]         s_tdata = '0;    // [7:0] elapsed_cycles
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  // [7:0] line_number, [9:8] lcd_mode, [10] coincidence, [11] stat_irq,
  // [12] vblank_irq, [15:13] zero
  logic [RES_W-1:0]   m_tdata;
  logic               cfg_wen;
  logic [IDX_W-1:0]   cfg_addr;
  logic [CFG_W-1:0]   cfg_wdata;

  lcd_scanline_mode_timer uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_wen   (cfg_wen),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  logic [7:0] pending_elapsed[$];
  result_t    expected_status[$];
  int         mismatch_count = 0;
  int         cycle_count = 0;
  logic       in_fire = 1'b0;

  // Shadow of the registers and of the timing state.
  cfg_t        regs_q = '{display_enable: 1'b1, default: '0};
  int          dot_count = int'(LINE_CYCLES);
  logic [7:0]  line_q = '0;
  logic [1:0]  mode_q = MODE_HBLANK;
  logic        coin_q = 1'b0;

  function automatic result_t step_timing(logic [7:0] elapsed);
    result_t    r;
    logic [1:0] next_mode;
    logic       irq_on;
    logic       stat;
    logic       vbl;
    stat = 1'b0;
    vbl = 1'b0;
    if (!regs_q.display_enable) begin
      // Display off holds the timing in reset; the coincidence flag is kept.
      dot_count = int'(LINE_CYCLES);
      line_q = '0;
      mode_q = MODE_VBLANK;
    end else begin
      if (line_q >= VISIBLE_LINES)
        next_mode = MODE_VBLANK;
      else if (dot_count >= int'(OAM_START))
        next_mode = MODE_OAM;
      else if (dot_count >= int'(TRANSFER_START))
        next_mode = MODE_TRANSFER;
      else
        next_mode = MODE_HBLANK;
      case (next_mode)
        MODE_HBLANK: irq_on = regs_q.hblank_irq_enable;
        MODE_VBLANK: irq_on = regs_q.vblank_mode_irq_enable;
        MODE_OAM:    irq_on = regs_q.oam_irq_enable;
        default:     irq_on = 1'b0;
      endcase
      if (next_mode != mode_q && irq_on)
        stat = 1'b1;
      mode_q = next_mode;
      if (line_q == regs_q.line_compare) begin
        coin_q = 1'b1;
        if (regs_q.compare_irq_enable)
          stat = 1'b1;
      end else begin
        coin_q = 1'b0;
      end
      dot_count -= int'(elapsed);
      if (dot_count <= 0) begin
        line_q = line_q + 8'd1;
        dot_count = int'(LINE_CYCLES);
        if (line_q == VISIBLE_LINES)
          vbl = 1'b1;
        if (line_q > LAST_LINE)
          line_q = '0;
      end
    end
    r.line_number = line_q;
    r.lcd_mode = mode_q;
    r.coincidence = coin_q;
    r.stat_irq = stat;
    r.vblank_irq = vbl;
    return r;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // Input acceptance and result checking, both sampled at the rising edge.
  always @(posedge clk) begin
    result_t want;
    if (!rst && s_tvalid && s_tready) begin
      expected_status.push_back(step_timing(s_tdata));
      in_fire <= 1'b1;
    end else begin
      in_fire <= 1'b0;
    end
    if (!rst && m_tvalid && m_tready) begin
      if (expected_status.size() == 0) begin
        $error("result word 0x%04h arrived with no expectation", m_tdata);
        mismatch_count++;
      end else begin
        want = expected_status.pop_front();
        check_field("line_number", want.line_number, m_tdata[7:0]);
        check_field("lcd_mode", want.lcd_mode, m_tdata[9:8]);
        check_field("coincidence", want.coincidence, m_tdata[10]);
        check_field("stat_irq", want.stat_irq, m_tdata[11]);
        check_field("vblank_irq", want.vblank_irq, m_tdata[12]);
        check_field("padding", 0, m_tdata[15:13]);
      end
    end
  end

  // Sender: bursts of random length separated by random gaps.
  int burst_left = 1;
  int gap_left = 0;

  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
    end else if (!s_tvalid || in_fire) begin
      if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (pending_elapsed.size() > 0) begin
        s_tvalid <= 1'b1;
        s_tdata <= pending_elapsed.pop_front();
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: a stall pattern cycling through four modes, plus a long
  // periodic hold-off so the block fills and stalls its input.
  int rx_cycle = 0;
  int hold_left = 0;

  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (rx_cycle % 1024 == 600) begin
        hold_left = 150;
        m_tready <= 1'b0;
      end else begin
        case ((rx_cycle / 128) % 4)
          0: m_tready <= 1'b1;
          1: m_tready <= ($urandom_range(0, 3) != 0);
          2: m_tready <= (rx_cycle % 3 != 0);
          default: m_tready <= $urandom_range(0, 1);
        endcase
      end
      rx_cycle++;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic wait_idle();
    while (pending_elapsed.size() != 0 || s_tvalid || expected_status.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_wen <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_DISPLAY_ENABLE: regs_q.display_enable = val[0];
      REG_HBLANK_IRQ_EN:  regs_q.hblank_irq_enable = val[0];
      REG_VBLANK_IRQ_EN:  regs_q.vblank_mode_irq_enable = val[0];
      REG_OAM_IRQ_EN:     regs_q.oam_irq_enable = val[0];
      REG_COMPARE_IRQ_EN: regs_q.compare_irq_enable = val[0];
      REG_LINE_COMPARE:   regs_q.line_compare = val;
      default: ;
    endcase
  endtask

  // Rewrites every register once the block has drained. The upper bits of
  // the one-bit registers carry noise that the block has to mask off.
  task automatic program_regs(input logic en, input logic hb, input logic vb,
                              input logic oam, input logic cmp,
                              input logic [7:0] compare);
    wait_idle();
    repeat (LATENCY + 2) @(negedge clk);
    write_reg(REG_DISPLAY_ENABLE, {7'($urandom), en});
    write_reg(REG_HBLANK_IRQ_EN, {7'($urandom), hb});
    write_reg(REG_VBLANK_IRQ_EN, {7'($urandom), vb});
    write_reg(REG_OAM_IRQ_EN, {7'($urandom), oam});
    write_reg(REG_COMPARE_IRQ_EN, {7'($urandom), cmp});
    write_reg(REG_LINE_COMPARE, compare);
    write_reg(REG_SPARE_LO, 8'($urandom));
    write_reg(REG_SPARE_HI, 8'($urandom));
    @(negedge clk);
    cfg_wen <= 1'b0;
  endtask

  function automatic logic [7:0] random_elapsed();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 4)
      return 8'($urandom_range(0, 255));
    else if (pick < 8)
      return 8'($urandom_range(160, 255));
    else if (pick == 8)
      return 8'($urandom_range(0, 15));
    else
      return $urandom_range(0, 1) ? 8'd255 : 8'd0;
  endfunction

  initial begin
    int       count;
    logic [7:0] compare;
    rst = 1'b1;
    cfg_wen = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // Reset settings: zero steps hold the counter, large ones wrap lines.
    pending_elapsed = '{8'd0, 8'd0, 8'd255, 8'd1, 8'd255, 8'd128};

    // All interrupts on: walk from transfer on line 1 through hblank into OAM on line 2.
    program_regs(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 8'd1);
    pending_elapsed = '{8'd0, 8'd0, 8'd80, 8'd0, 8'd96, 8'd76, 8'd1, 8'd255, 8'd255};

    // Display off forces vblank mode and line 0 without interrupts.
    program_regs(1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 8'd0);
    pending_elapsed = '{8'd255, 8'd0, 8'd7};

    program_regs(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 8'd0);
    pending_elapsed = '{8'd255, 8'd200, 8'd1};

    for (int p = 0; p < 10; p++) begin
      case (p)
        0: compare = 8'd0;
        1: compare = 8'd255;
        2: compare = LAST_LINE;
        3: compare = VISIBLE_LINES;
        default: compare = 8'($urandom_range(0, 159));
      endcase
      if (p == 0)
        program_regs(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, compare);
      else if (p == 1)
        program_regs(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, compare);
      else
        program_regs(p != 6, 1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                     compare);
      count = (p == 6) ? 40 : 110;
      for (int i = 0; i < count; i++)
        pending_elapsed.push_back(random_elapsed());
    end

    wait_idle();
    repeat (LATENCY + 8) @(negedge clk);
    if (expected_status.size() != 0) begin
      $error("%0d expected results never arrived", expected_status.size());
      mismatch_count++;
    end
    if (mismatch_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

// ===== lcd_scanline_mode_timer.f =====
rtl/lsmt_pkg.sv
rtl/lsmt_cfg.sv
rtl/lsmt_core.sv
rtl/lcd_scanline_mode_timer.sv
tb/testbench.sv
